[rtl/lni_pkg.sv]
// Shared types, constants and helpers for the lattice neighbor index block.
// Used by lni_coord_split and lattice_neighbor_index; depends on nothing.
package lni_pkg;

	localparam int SITE_W    = 12;
	localparam int SIDE_W    = 13;
	localparam int AXIS_W    = 2;
	localparam int DIM_W     = 2;
	localparam int CIDX_W    = 3;
	localparam int MAX_SIDE  = 4096;
	localparam int MAX_SITES = 4096;
	localparam int DIV_STEPS = SITE_W;
	localparam int SPLIT_STAGES = 2 * DIV_STEPS;

	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
	localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

	typedef enum logic [CIDX_W-1:0] {
		CFG_SIDE_X    = 3'd0,
		CFG_SIDE_Y    = 3'd1,
		CFG_SIDE_Z    = 3'd2,
		CFG_DIMENSION = 3'd3,
		CFG_WRAP_X    = 3'd4,
		CFG_WRAP_Y    = 3'd5,
		CFG_WRAP_Z    = 3'd6
	} lni_cfg_idx_t;

	typedef struct packed {
		logic [SITE_W-1:0] site;
		logic [AXIS_W-1:0] axis;
		logic              backward;
	} lni_in_t;

	typedef struct packed {
		logic [SITE_W-1:0] neighbor;
		logic              neighbor_valid;
		logic [SITE_W-1:0] coord_x;
		logic [SITE_W-1:0] coord_y;
		logic [SITE_W-1:0] coord_z;
		logic              site_error;
	} lni_out_t;

	typedef struct packed {
		logic [SIDE_W-1:0] len_x;
		logic [SIDE_W-1:0] len_y;
	} lni_geom_t;

	// one beat inside the split pipeline
	typedef struct packed {
		logic [SITE_W-1:0] site;
		logic [AXIS_W-1:0] axis;
		logic              backward;
		logic [SITE_W-1:0] num;
		logic [SITE_W-1:0] rem;
		logic [SITE_W-1:0] quo;
		logic [SITE_W-1:0] crd_x;
	} lni_div_t;

	function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] s);
		logic [SIDE_W-1:0] r;
		r = s;
		if (s == '0) begin
			r = SIDE_W'(1);
		end else if (s > SIDE_W'(MAX_SIDE)) begin
			r = SIDE_W'(MAX_SIDE);
		end
		return r;
	endfunction

endpackage

[rtl/lni_coord_split.sv]
// Pipelined coordinate split: site / len_x, then quotient / len_y, one bit per stage.
// Depends on lni_pkg.
module lni_coord_split (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  lni_pkg::lni_in_t   in_item,
	input  lni_pkg::lni_geom_t geom,
	output logic               out_valid,
	output lni_pkg::lni_div_t  out_beat
);
	import lni_pkg::*;

	logic     vld_s [SPLIT_STAGES];
	lni_div_t dat_s [SPLIT_STAGES];

	for (genvar j = 0; j < SPLIT_STAGES; j++) begin : g_stg
		localparam int K = j % DIV_STEPS;
		lni_div_t          src;
		lni_div_t          nxt;
		logic              src_v;
		logic [SIDE_W-1:0] dvs;

		if (j == 0) begin : g_first
			always_comb begin
				src_v         = in_valid;
				src.site      = in_item.site;
				src.axis      = in_item.axis;
				src.backward  = in_item.backward;
				src.num       = in_item.site;
				src.rem       = '0;
				src.quo       = '0;
				src.crd_x     = '0;
			end
		end else if (j == DIV_STEPS) begin : g_turn
			always_comb begin
				src_v     = vld_s[j-1];
				src       = dat_s[j-1];
				src.num   = dat_s[j-1].quo;
				src.crd_x = dat_s[j-1].rem;
				src.rem   = '0;
				src.quo   = '0;
			end
		end else begin : g_mid
			always_comb begin
				src_v = vld_s[j-1];
				src   = dat_s[j-1];
			end
		end

		assign dvs = (j < DIV_STEPS) ? geom.len_x : geom.len_y;

		always_comb begin
			logic [SIDE_W-1:0] t;
			logic              ge;
			t  = {src.rem, src.num[SITE_W-1-K]};
			ge = (t >= dvs);
			nxt     = src;
			nxt.rem = ge ? SITE_W'(t - dvs) : SITE_W'(t);
			nxt.quo = {src.quo[SITE_W-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else begin
				vld_s[j] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			dat_s[j] <= nxt;
		end
	end

	assign out_valid = vld_s[SPLIT_STAGES-1];
	assign out_beat  = dat_s[SPLIT_STAGES-1];

endmodule

[rtl/lattice_neighbor_index.sv]
// Top level of the lattice neighbor index block: config registers, coordinate split,
// neighbor step and rebuild pipeline. Depends on lni_pkg and lni_coord_split.
//
// One query per clock, every clock: busy is always low, so start alone accepts a beat.
// Each result appears on result with done high for one cycle, once its query has passed
// through the pipeline: the two bit-serial divider chains (12 stages each) that split
// the site into coordinates, plus four stages for the step, two multiplies and the
// range check. The receiver cannot stall and nothing is buffered. Write configuration
// only while no query is in flight; cfg_ready is always high, and a query may follow
// a configuration write from the next cycle on.
module lattice_neighbor_index (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  lni_pkg::lni_in_t            item,
	output logic                        busy,
	output logic                        done,
	output lni_pkg::lni_out_t           result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lni_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [lni_pkg::SIDE_W-1:0]  cfg_data
);
	import lni_pkg::*;

	logic [SIDE_W-1:0] side_x_q, side_y_q, side_z_q;
	logic [DIM_W-1:0]  dimension_q;
	logic              wrap_x_q, wrap_y_q, wrap_z_q;
	logic [SIDE_W-1:0] p01_q, total_q;

	logic [DIM_W-1:0]  dim_eff;
	logic [SIDE_W-1:0] len_x, len_y, len_z;
	lni_geom_t         geom;

	logic              split_v;
	lni_div_t          split_b;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_x_q    <= SIDE_W'(1);
			side_y_q    <= SIDE_W'(1);
			side_z_q    <= SIDE_W'(1);
			dimension_q <= DIM_W'(1);
			wrap_x_q    <= 1'b0;
			wrap_y_q    <= 1'b0;
			wrap_z_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SIDE_X:    side_x_q    <= cfg_data;
				CFG_SIDE_Y:    side_y_q    <= cfg_data;
				CFG_SIDE_Z:    side_z_q    <= cfg_data;
				CFG_DIMENSION: dimension_q <= cfg_data[DIM_W-1:0];
				CFG_WRAP_X:    wrap_x_q    <= cfg_data[0];
				CFG_WRAP_Y:    wrap_y_q    <= cfg_data[0];
				CFG_WRAP_Z:    wrap_z_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		dim_eff = (dimension_q == '0) ? DIM_W'(1) : dimension_q;
		len_x   = clamp_side(side_x_q);
		len_y   = (dim_eff >= DIM_W'(2)) ? clamp_side(side_y_q) : SIDE_W'(1);
		len_z   = (dim_eff >= DIM_W'(3)) ? clamp_side(side_z_q) : SIDE_W'(1);
		geom.len_x = len_x;
		geom.len_y = len_y;
	end

	// saturating site count, two registered multiplies
	always_ff @(posedge clk or negedge arst_n) begin
		logic [2*SIDE_W-1:0] pa;
		logic [2*SIDE_W-1:0] pb;
		if (!arst_n) begin
			p01_q   <= SIDE_W'(1);
			total_q <= SIDE_W'(1);
		end else begin
			pa = (2*SIDE_W)'(len_x) * (2*SIDE_W)'(len_y);
			pb = (2*SIDE_W)'(p01_q) * (2*SIDE_W)'(len_z);
			p01_q   <= (pa > (2*SIDE_W)'(MAX_SITES)) ? SIDE_W'(MAX_SITES) : SIDE_W'(pa);
			total_q <= (pb > (2*SIDE_W)'(MAX_SITES)) ? SIDE_W'(MAX_SITES) : SIDE_W'(pb);
		end
	end

	lni_coord_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.in_item   (item),
		.geom      (geom),
		.out_valid (split_v),
		.out_beat  (split_b)
	);

	// stage 1: step along the chosen axis
	logic              v_s1, ok_s1;
	logic [SITE_W-1:0] site_s1, cx_s1, cy_s1, cz_s1, nx_s1, ny_s1, nz_s1;

	logic [AXIS_W-1:0] ax;
	logic [SITE_W-1:0] c_cur, c_new;
	logic [SIDE_W-1:0] c_len;
	logic              c_wrap, c_ok;

	always_comb begin
		ax = (split_b.axis >= AXIS_W'(dim_eff)) ? AXIS_X : split_b.axis;
		case (ax)
			AXIS_Y: begin
				c_cur  = split_b.rem;
				c_len  = len_y;
				c_wrap = wrap_y_q;
			end
			AXIS_Z: begin
				c_cur  = split_b.quo;
				c_len  = len_z;
				c_wrap = wrap_z_q;
			end
			default: begin
				c_cur  = split_b.crd_x;
				c_len  = len_x;
				c_wrap = wrap_x_q;
			end
		endcase
		c_ok  = 1'b1;
		c_new = c_cur;
		if (!split_b.backward) begin
			if (({1'b0, c_cur} + SIDE_W'(1)) >= c_len) begin
				if (c_wrap) c_new = '0;
				else c_ok = 1'b0;
			end else begin
				c_new = c_cur + SITE_W'(1);
			end
		end else begin
			if (c_cur == '0) begin
				if (c_wrap) c_new = SITE_W'(c_len - SIDE_W'(1));
				else c_ok = 1'b0;
			end else begin
				c_new = c_cur - SITE_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= split_v;
		end
	end

	always_ff @(posedge clk) begin
		site_s1 <= split_b.site;
		cx_s1   <= split_b.crd_x;
		cy_s1   <= split_b.rem;
		cz_s1   <= split_b.quo;
		ok_s1   <= c_ok;
		nx_s1   <= (ax == AXIS_X) ? c_new : split_b.crd_x;
		ny_s1   <= (ax == AXIS_Y) ? c_new : split_b.rem;
		nz_s1   <= (ax == AXIS_Z) ? c_new : split_b.quo;
	end

	// stage 2: len_y * nz, kept mod 4096
	logic              v_s2, ok_s2;
	logic [SITE_W-1:0] site_s2, cx_s2, cy_s2, cz_s2, nx_s2, ny_s2, m1_s2;
	logic [SIDE_W+SITE_W-1:0] p1;

	assign p1 = (SIDE_W+SITE_W)'(len_y) * (SIDE_W+SITE_W)'(nz_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		site_s2 <= site_s1;
		cx_s2   <= cx_s1;
		cy_s2   <= cy_s1;
		cz_s2   <= cz_s1;
		ok_s2   <= ok_s1;
		nx_s2   <= nx_s1;
		ny_s2   <= ny_s1;
		m1_s2   <= p1[SITE_W-1:0];
	end

	// stage 3: len_x * (ny + m1), kept mod 4096
	logic              v_s3, ok_s3;
	logic [SITE_W-1:0] site_s3, cx_s3, cy_s3, cz_s3, nx_s3, m2_s3;
	logic [SITE_W-1:0] row;
	logic [SIDE_W+SITE_W-1:0] p2;

	assign row = m1_s2 + ny_s2;
	assign p2  = (SIDE_W+SITE_W)'(len_x) * (SIDE_W+SITE_W)'(row);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		site_s3 <= site_s2;
		cx_s3   <= cx_s2;
		cy_s3   <= cy_s2;
		cz_s3   <= cz_s2;
		ok_s3   <= ok_s2;
		nx_s3   <= nx_s2;
		m2_s3   <= p2[SITE_W-1:0];
	end

	// stage 4: final add, range check, result register
	logic     v_s4;
	lni_out_t res_s4;
	lni_out_t res_d;
	logic     bad;

	always_comb begin
		bad   = ({1'b0, site_s3} >= total_q);
		res_d = '0;
		if (bad) begin
			res_d.site_error = 1'b1;
		end else begin
			res_d.coord_x        = cx_s3;
			res_d.coord_y        = cy_s3;
			res_d.coord_z        = cz_s3;
			res_d.neighbor_valid = ok_s3;
			res_d.neighbor       = ok_s3 ? (m2_s3 + nx_s3) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		res_s4 <= res_d;
	end

	assign done   = v_s4;
	assign result = res_s4;

`ifndef SYNTHESIS
	a_done_follows_s3: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(v_s3))
		else $error("result strobe without a beat in the stage before");

	a_err_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.site_error) |-> (!result.neighbor_valid && result.neighbor == '0
			&& result.coord_x == '0 && result.coord_y == '0 && result.coord_z == '0))
		else $error("site error with nonzero result fields");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.neighbor_valid) |-> (result.neighbor == '0))
		else $error("neighbor nonzero while not valid");

	a_coord_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.site_error) |-> (({1'b0, result.coord_x} < len_x)
			&& ({1'b0, result.coord_y} < len_y)))
		else $error("coordinate outside its side length");
`endif

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Testbench for lattice_neighbor_index: queued queries and config beats, a self-contained
// neighbor predictor, and a scoreboard that checks each result field. Needs lni_pkg and the RTL.
module tb;
	import lni_pkg::*;

	localparam int          CLK_HALF    = 2;
	localparam int          LATENCY     = 28;
	localparam int          QUIET_LIMIT = 2000;
	localparam int          IDLE_PCT    = 28;
	localparam logic [2:0]  CFG_UNUSED  = 3'd7;
	localparam logic [1:0]  AXIS_NONE   = 2'd3;

	typedef struct {
		bit                is_cfg;
		bit                calm;
		logic [2:0]        idx;
		logic [SIDE_W-1:0] data;
		lni_in_t           q;
	} beat_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              start     = 1'b0;
	lni_in_t           item      = '0;
	logic              cfg_valid = 1'b0;
	logic [2:0]        cfg_index = '0;
	logic [SIDE_W-1:0] cfg_data  = '0;
	logic              cfg_ready;
	logic              busy;
	logic              done;
	lni_out_t          result;

	beat_t             plan_q[$];
	lni_out_t          neighbor_q[$];
	logic [SIDE_W-1:0] side_reg [3];
	logic [1:0]        dim_reg;
	logic              wrap_reg [3];
	int                sent_cnt = 0;
	int                got_cnt  = 0;
	int                err_cnt  = 0;
	int                quiet    = 0;

	lattice_neighbor_index u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	function automatic longint unsigned side_len(logic [SIDE_W-1:0] s);
		if (s == 0) return 1;
		if (s > MAX_SIDE) return MAX_SIDE;
		return s;
	endfunction

	function automatic lni_out_t neighbor_of(lni_in_t q);
		longint unsigned len [3];
		longint unsigned crd [3];
		longint unsigned nb [3];
		longint unsigned tot;
		longint unsigned c;
		int unsigned     dim;
		int unsigned     ax;
		bit              ok;
		lni_out_t        r;
		r = '0;
		dim = (dim_reg == 0) ? 1 : dim_reg;
		len[0] = side_len(side_reg[0]);
		len[1] = (dim >= 2) ? side_len(side_reg[1]) : 1;
		len[2] = (dim >= 3) ? side_len(side_reg[2]) : 1;
		tot = len[0] * len[1] * len[2];
		if (tot > MAX_SITES) tot = MAX_SITES;
		if (q.site >= tot) begin
			r.site_error = 1'b1;
			return r;
		end
		crd[0] = q.site % len[0];
		crd[1] = (q.site / len[0]) % len[1];
		crd[2] = q.site / (len[0] * len[1]);
		ax = q.axis;
		if (ax >= dim) ax = 0;
		c = crd[ax];
		ok = 1'b1;
		if (!q.backward) begin
			if (c + 1 >= len[ax]) begin
				if (wrap_reg[ax]) c = 0;
				else ok = 1'b0;
			end else begin
				c = c + 1;
			end
		end else begin
			if (c == 0) begin
				if (wrap_reg[ax]) c = len[ax] - 1;
				else ok = 1'b0;
			end else begin
				c = c - 1;
			end
		end
		if (ok) begin
			nb = crd;
			nb[ax] = c;
			r.neighbor = SITE_W'(nb[0] + len[0] * (nb[1] + len[1] * nb[2]));
			r.neighbor_valid = 1'b1;
		end
		r.coord_x = SITE_W'(crd[0]);
		r.coord_y = SITE_W'(crd[1]);
		r.coord_z = SITE_W'(crd[2]);
		return r;
	endfunction

	task automatic add_cfg(logic [2:0] idx, logic [SIDE_W-1:0] data);
		beat_t b;
		b = '{is_cfg: 1'b1, calm: 1'b0, idx: idx, data: data, q: '0};
		plan_q.push_back(b);
	endtask

	task automatic add_query(logic [SITE_W-1:0] s, logic [1:0] a, bit bk, bit calm);
		beat_t b;
		b = '{is_cfg: 1'b0, calm: calm, idx: '0, data: '0, q: '{site: s, axis: a, backward: bk}};
		plan_q.push_back(b);
	endtask

	function automatic logic [SIDE_W-1:0] pick_side();
		case ($urandom_range(9))
			0: return 13'd0;
			1: return 13'd1;
			2: return 13'd2;
			3: return 13'd4096;
			4: return 13'($urandom_range(8191, 4097));
			5, 6: return 13'($urandom_range(64, 3));
			default: return 13'($urandom_range(12, 3));
		endcase
	endfunction

	// one lattice setting followed by n queries biased toward edges and corners
	task automatic plan_phase(logic [SIDE_W-1:0] sx, logic [SIDE_W-1:0] sy,
			logic [SIDE_W-1:0] sz, logic [1:0] dim, logic [2:0] wraps, int n, bit calm);
		longint unsigned   len [3];
		longint unsigned   crd [3];
		longint unsigned   tot;
		longint unsigned   s;
		logic [SIDE_W-1:0] wd;
		int unsigned       pick;
		int unsigned       d;
		add_cfg(CFG_SIDE_X, sx);
		add_cfg(CFG_SIDE_Y, sy);
		add_cfg(CFG_SIDE_Z, sz);
		wd = SIDE_W'(dim);
		if ($urandom_range(3) == 0) wd[SIDE_W-1:2] = 11'($urandom);
		add_cfg(CFG_DIMENSION, wd);
		for (int k = 0; k < 3; k++) begin
			wd = SIDE_W'(wraps[k]);
			if ($urandom_range(3) == 0) wd[SIDE_W-1:1] = 12'($urandom);
			add_cfg(3'(CFG_WRAP_X) + 3'(k), wd);
		end
		d = (dim == 0) ? 1 : dim;
		len[0] = side_len(sx);
		len[1] = (d >= 2) ? side_len(sy) : 1;
		len[2] = (d >= 3) ? side_len(sz) : 1;
		tot = len[0] * len[1] * len[2];
		if (tot > MAX_SITES) tot = MAX_SITES;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				s = $urandom_range(32'(tot - 1));
			end else if (pick < 75) begin
				for (int k = 0; k < 3; k++) begin
					case ($urandom_range(2))
						0: crd[k] = 0;
						1: crd[k] = len[k] - 1;
						default: crd[k] = $urandom_range(32'(len[k] - 1));
					endcase
				end
				s = crd[0] + len[0] * (crd[1] + len[1] * crd[2]);
			end else if (pick < 85) begin
				s = (pick % 2) ? tot - 1 : tot;
			end else begin
				s = $urandom;
			end
			add_query(SITE_W'(s), 2'($urandom_range(3)), 1'($urandom_range(1)), calm);
		end
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endtask

	// driver: queries and config beats in plan order, config only with nothing in flight
	always @(posedge clk or negedge arst_n) begin : driver
		beat_t b;
		bit    go_q;
		bit    go_cfg;
		if (!arst_n) begin
			start     <= 1'b0;
			cfg_valid <= 1'b0;
			item      <= '0;
			cfg_index <= '0;
			cfg_data  <= '0;
			side_reg  = '{13'd1, 13'd1, 13'd1};
			dim_reg   = 2'd1;
			wrap_reg  = '{1'b0, 1'b0, 1'b0};
		end else begin
			if (start && !busy) begin
				neighbor_q.push_back(neighbor_of(item));
				sent_cnt++;
				void'(plan_q.pop_front());
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SIDE_X:    side_reg[0] = cfg_data;
					CFG_SIDE_Y:    side_reg[1] = cfg_data;
					CFG_SIDE_Z:    side_reg[2] = cfg_data;
					CFG_DIMENSION: dim_reg = cfg_data[1:0];
					CFG_WRAP_X:    wrap_reg[0] = cfg_data[0];
					CFG_WRAP_Y:    wrap_reg[1] = cfg_data[0];
					CFG_WRAP_Z:    wrap_reg[2] = cfg_data[0];
					default: ;
				endcase
				void'(plan_q.pop_front());
			end
			go_q = 1'b0;
			go_cfg = 1'b0;
			if (plan_q.size() > 0) begin
				b = plan_q[0];
				if (b.is_cfg) begin
					go_cfg = (sent_cnt == got_cnt) && ($urandom_range(99) >= IDLE_PCT);
				end else begin
					go_q = b.calm || ($urandom_range(99) >= IDLE_PCT);
				end
			end
			start <= go_q;
			cfg_valid <= go_cfg;
			if (go_q) item <= b.q;
			if (go_cfg) begin
				cfg_index <= b.idx;
				cfg_data  <= b.data;
			end
		end
	end

	// monitor: every done beat is matched against the oldest predicted lookup
	always @(posedge clk) begin : monitor
		lni_out_t w;
		if (arst_n && done) begin
			if (neighbor_q.size() == 0) begin
				$error("result with no query pending: neighbor %0d", result.neighbor);
				err_cnt++;
			end else begin
				w = neighbor_q.pop_front();
				check_field("neighbor", w.neighbor, result.neighbor);
				check_field("neighbor_valid", w.neighbor_valid, result.neighbor_valid);
				check_field("coord_x", w.coord_x, result.coord_x);
				check_field("coord_y", w.coord_y, result.coord_y);
				check_field("coord_z", w.coord_z, result.coord_z);
				check_field("site_error", w.site_error, result.site_error);
				got_cnt <= got_cnt + 1;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (start && !busy) || (cfg_valid && cfg_ready) || done) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		// reset lattice: single site, open boundary
		add_query(12'd0, AXIS_X, 1'b0, 1'b0);
		add_query(12'd0, AXIS_NONE, 1'b1, 1'b0);
		add_query(12'd4095, AXIS_Z, 1'b0, 1'b0);
		// 4 x 3 x 2, periodic in x and z, open in y
		add_cfg(CFG_SIDE_X, 13'd4);
		add_cfg(CFG_SIDE_Y, 13'd3);
		add_cfg(CFG_SIDE_Z, 13'd2);
		add_cfg(CFG_DIMENSION, 13'd3);
		add_cfg(CFG_WRAP_X, 13'd1);
		add_cfg(CFG_WRAP_Y, 13'd0);
		add_cfg(CFG_WRAP_Z, 13'd1);
		add_query(12'd0, AXIS_X, 1'b1, 1'b0);
		add_query(12'd3, AXIS_X, 1'b0, 1'b0);
		add_query(12'd0, AXIS_Y, 1'b1, 1'b0);
		add_query(12'd8, AXIS_Y, 1'b0, 1'b0);
		add_query(12'd5, AXIS_Y, 1'b0, 1'b0);
		add_query(12'd13, AXIS_Y, 1'b1, 1'b0);
		add_query(12'd0, AXIS_Z, 1'b1, 1'b0);
		add_query(12'd23, AXIS_Z, 1'b0, 1'b0);
		add_query(12'd23, AXIS_NONE, 1'b0, 1'b0);
		add_query(12'd24, AXIS_X, 1'b0, 1'b0);
		add_query(12'd4095, AXIS_Z, 1'b1, 1'b0);
		add_cfg(CFG_UNUSED, 13'($urandom));

		plan_phase(13'd4096, 13'd0, 13'd8191, 2'd0, 3'b001, 80, 1'b0);
		plan_phase(13'd64, 13'd64, 13'd4096, 2'd3, 3'b111, 80, 1'b0);
		plan_phase(13'd1, 13'd1, 13'd8191, 2'd3, 3'b011, 60, 1'b0);
		for (int ph = 0; ph < 8; ph++) begin
			plan_phase(pick_side(), pick_side(), pick_side(), 2'($urandom_range(3)),
				3'($urandom), 100, ph == 4);
		end
		plan_phase(13'd1, 13'd1, 13'd1, 2'd1, 3'b000, 20, 1'b0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (plan_q.size() != 0 || got_cnt != sent_cnt) @(posedge clk);
		repeat (LATENCY + 12) @(posedge clk);
		if (err_cnt == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
